[hdl/spring_particle_grid_update_unit_macros.svh]
// Assertion macros for the spring particle grid update unit.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SPRING_PARTICLE_GRID_UPDATE_UNIT_MACROS_SVH
`define SPRING_PARTICLE_GRID_UPDATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPGU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SPGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPGU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SPGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/spgu_pkg.sv]
// Shared types, constants and arithmetic helpers of the particle grid update unit.
// No dependencies; imported by spring_particle_grid_update_unit.
`default_nettype none

package spgu_pkg;

    localparam int DEF_GRID_SIDE     = 11;
    localparam int DEF_FRACTION_BITS = 8;
    localparam int WINDOW_SIDE       = 5;
    localparam int HALF_WIN          = WINDOW_SIDE / 2;
    localparam int PITCH             = 5;
    localparam int MAX_PARTICLES     = 128;

    localparam int POS_W      = 20;
    localparam int VEL_W      = 24;
    localparam int POS_MAX_INT = 524287;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7F_FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh80_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 20'sh8_0000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LEFT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_TOP  = 2'd3;

    localparam logic [15:0] RESET_DAMPING   = 16'd42598;
    localparam logic [5:0]  RESET_STIFFNESS = 6'd10;
    localparam logic [7:0]  RESET_LEFT      = 8'd39;
    localparam logic [7:0]  RESET_TOP       = 8'd7;

    // per-particle state held in the state memory; index 0 is x, 1 is y
    typedef struct packed {
        logic [1:0][POS_W-1:0] pos;
        logic [1:0][VEL_W-1:0] vel;
    } t_state;

    localparam logic signed [2:0] OFFSET_TABLE [WINDOW_SIDE][WINDOW_SIDE] = '{
        '{3'sd0,  3'sd2, 3'sd0, -3'sd2,  3'sd0},
        '{3'sd3,  3'sd3, 3'sd0, -3'sd3, -3'sd3},
        '{3'sd2,  3'sd2, 3'sd0, -3'sd2, -3'sd2},
        '{3'sd3,  3'sd3, 3'sd0, -3'sd3, -3'sd3},
        '{3'sd0,  3'sd2, 3'sd0, -3'sd2,  3'sd0}
    };

    function automatic logic signed [2:0] offset_at(input logic [2:0] r, input logic [2:0] c);
        logic signed [2:0] v;
        v = '0;
        if (int'(r) < WINDOW_SIDE && int'(c) < WINDOW_SIDE) begin
            v = OFFSET_TABLE[r][c];
        end
        return v;
    endfunction

    // rest point of a grid line, saturated to the position range
    function automatic logic [POS_W-1:0] origin_of(input logic [7:0] base,
                                                   input logic [4:0] idx,
                                                   input int fb);
        int o;
        o = (int'(base) + int'(idx) * PITCH) <<< fb;
        if (o > POS_MAX_INT) begin
            o = POS_MAX_INT;
        end
        return POS_W'(o);
    endfunction

    // shift right by 16, round to nearest, ties away from zero
    function automatic logic signed [24:0] round_q16(input logic signed [40:0] v);
        logic [40:0] mag;
        logic [40:0] m;
        mag = v[40] ? 41'(-v) : 41'(v);
        m   = (mag + 41'd32768) >> 16;
        return v[40] ? -$signed(25'(m)) : $signed(25'(m));
    endfunction

endpackage

`default_nettype wire

[hdl/spring_particle_grid_update_unit.sv]
// Spring-damper particle grid update: eight-stage pipeline around a per-particle state memory.
// Depends on spgu_pkg and spring_particle_grid_update_unit_macros.svh.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------------
//  input     | in        | i_valid / o_stall    | i_particle, i_cursor_x/y, i_elapsed
//  result    | out       | o_valid / i_stall    | o_particle_out, o_pos_x/y, o_in_window
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One transaction per cycle while o_stall is low; results leave through the result register after stage 8.
// A transaction naming a particle still in the pipeline waits until the earlier one has
// written the state memory back (read-modify-write loop through the memory).
// Reset restores the register defaults and clears the per-particle valid flags; an entry
// never written reads as its origin at the default grid placement. No clearing pass.
// A stalled result freezes every stage and raises o_stall.
`default_nettype none
`include "spring_particle_grid_update_unit_macros.svh"

module spring_particle_grid_update_unit #(
    parameter int GRID_SIDE     = spgu_pkg::DEF_GRID_SIDE,
    parameter int FRACTION_BITS = spgu_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [spgu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [spgu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [6:0]                           i_particle,
    input  logic [11:0]                          i_cursor_x,
    input  logic [11:0]                          i_cursor_y,
    input  logic [15:0]                          i_elapsed,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [6:0]                           o_particle_out,
    output logic signed [spgu_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [spgu_pkg::POS_W-1:0]    o_pos_y,
    output logic                                 o_in_window
);
    import spgu_pkg::*;

    localparam int NUM   = GRID_SIDE * GRID_SIDE;
    localparam int DEPTH = (NUM < MAX_PARTICLES) ? NUM : MAX_PARTICLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GRID_SIDE);
    localparam int DW    = ((RW + FRACTION_BITS > 12) ? RW + FRACTION_BITS : 12) + 1;
    localparam int NS    = 8;

    // configuration
    logic [15:0] r_damping;
    logic [5:0]  r_stiffness;
    logic [7:0]  r_grid_left;
    logic [7:0]  r_grid_top;

    // stage control
    logic        r_vld [NS];
    logic [6:0]  r_pid [NS];
    logic        r_rng [NS];

    // state memory and its valid flags
    t_state      r_mem [DEPTH];
    logic        r_init [DEPTH];

    logic        w_en;
    logic        w_hazard;
    logic        w_accept;
    logic        w_in_rng;
    logic        w_we;
    logic [AW-1:0] w_wr_addr;
    t_state      w_wr_data;

    // stage 1
    logic [11:0] r_s1_cur [2];
    logic [15:0] r_s1_el;
    t_state      r_s1_mem;
    logic        r_s1_init;
    logic [RW-1:0] n_s2_row;
    logic [RW-1:0] n_s2_col;

    // stage 2
    logic [RW-1:0] r_s2_row;
    logic [RW-1:0] r_s2_col;
    logic [11:0] r_s2_cur [2];
    logic [15:0] r_s2_el;
    t_state      r_s2_mem;
    logic        r_s2_init;
    logic [RW-1:0] w_coord [2];
    logic signed [DW-1:0] w_d [2];
    logic        w_neg [2];
    logic [DW-1:0] w_mag [2];
    logic [DW-1:0] w_sh [2];
    logic        w_in_ax [2];
    logic [POS_W-1:0] w_rst_org [2];
    logic [POS_W-1:0] n_s3_org [2];
    logic [2:0]  n_s3_cell [2];
    logic        n_s3_in;
    logic signed [POS_W-1:0] n_s3_pos [2];
    logic signed [VEL_W-1:0] n_s3_vel [2];

    // stage 3
    logic [POS_W-1:0] r_s3_org [2];
    logic [2:0]  r_s3_cell [2];
    logic        r_s3_in;
    logic signed [POS_W-1:0] r_s3_pos [2];
    logic signed [VEL_W-1:0] r_s3_vel [2];
    logic [15:0] r_s3_el;
    logic signed [2:0]  w_off [2];
    logic signed [20:0] n_s4_tgt [2];

    // stage 4
    logic signed [20:0] r_s4_tgt [2];
    logic signed [POS_W-1:0] r_s4_pos [2];
    logic signed [VEL_W-1:0] r_s4_vel [2];
    logic [15:0] r_s4_el;
    logic        r_s4_in;
    logic signed [40:0] n_s5_pd [2];
    logic signed [21:0] n_s5_err [2];

    // stage 5
    logic signed [40:0] r_s5_pd [2];
    logic signed [21:0] r_s5_err [2];
    logic signed [POS_W-1:0] r_s5_pos [2];
    logic [15:0] r_s5_el;
    logic        r_s5_in;
    logic signed [24:0] n_s6_rd [2];
    logic signed [28:0] n_s6_ps [2];

    // stage 6
    logic signed [24:0] r_s6_rd [2];
    logic signed [28:0] r_s6_ps [2];
    logic signed [POS_W-1:0] r_s6_pos [2];
    logic [15:0] r_s6_el;
    logic        r_s6_in;
    logic signed [29:0] w_vs [2];
    logic signed [VEL_W-1:0] n_s7_vel [2];

    // stage 7
    logic signed [VEL_W-1:0] r_s7_vel [2];
    logic signed [POS_W-1:0] r_s7_pos [2];
    logic [15:0] r_s7_el;
    logic        r_s7_in;
    logic signed [40:0] n_s8_pe [2];

    // stage 8
    logic signed [40:0] r_s8_pe [2];
    logic signed [VEL_W-1:0] r_s8_vel [2];
    logic signed [POS_W-1:0] r_s8_pos [2];
    logic        r_s8_in;
    logic signed [25:0] w_ps [2];
    logic signed [POS_W-1:0] w_pn [2];

    // result register
    logic        r_o_vld;
    logic [6:0]  r_o_pid;
    logic signed [POS_W-1:0] r_o_pos [2];
    logic        r_o_in;

    // ------------------------------------------------------------------ handshake
    assign w_en     = !(r_o_vld && i_stall);
    assign w_in_rng = int'(i_particle) < NUM;

    always_comb begin
        w_hazard = 1'b0;
        for (int k = 0; k < NS; k++) begin
            if (r_vld[k] && r_pid[k] == i_particle) begin
                w_hazard = 1'b1;
            end
        end
    end

    assign o_stall  = !w_en || w_hazard;
    assign w_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping   <= RESET_DAMPING;
            r_stiffness <= RESET_STIFFNESS;
            r_grid_left <= RESET_LEFT;
            r_grid_top  <= RESET_TOP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DAMPING:   r_damping   <= i_cfg_data;
                CFG_STIFFNESS: r_stiffness <= i_cfg_data[5:0];
                CFG_GRID_LEFT: r_grid_left <= i_cfg_data[7:0];
                CFG_GRID_TOP:  r_grid_top  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pid[0] <= i_particle;
            r_rng[0] <= w_in_rng;
            for (int k = 1; k < NS; k++) begin
                r_pid[k] <= r_pid[k-1];
                r_rng[k] <= r_rng[k-1];
            end
        end
    end

    // ------------------------------------------------------------------ state memory
    assign w_we      = w_en && r_vld[NS-1] && r_rng[NS-1];
    assign w_wr_addr = r_pid[NS-1][AW-1:0];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_wr_data.pos[a] = w_pn[a];
            w_wr_data.vel[a] = r_s8_vel[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_en) begin
            r_s1_mem <= r_mem[i_particle[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_init[k] <= 1'b0;
            end
        end else if (w_we) begin
            r_init[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_init <= r_init[i_particle[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------ stage 1: row and column
    always_comb begin
        n_s2_row = '0;
        for (int k = 1; k < GRID_SIDE; k++) begin
            if (int'(r_pid[0]) >= k * GRID_SIDE) begin
                n_s2_row = RW'(k);
            end
        end
        n_s2_col = RW'(int'(r_pid[0]) - int'(n_s2_row) * GRID_SIDE);
    end

    // ------------------------------------------------------------------ stage 2: origins, window cell
    assign w_coord[0] = r_s2_col;
    assign w_coord[1] = r_s2_row;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_d[a]   = $signed(DW'({w_coord[a], {FRACTION_BITS{1'b0}}})) -
                       $signed(DW'(r_s2_cur[a]));
            w_neg[a] = w_d[a][DW-1];
            // truncate toward zero: shift the magnitude, then reapply the sign
            w_mag[a] = w_neg[a] ? DW'(-w_d[a]) : DW'(w_d[a]);
            w_sh[a]  = w_mag[a] >> FRACTION_BITS;
            w_in_ax[a] = w_sh[a] <= DW'(HALF_WIN);
            n_s3_cell[a] = w_neg[a] ? 3'd2 - {1'b0, w_sh[a][1:0]}
                                    : 3'd2 + {1'b0, w_sh[a][1:0]};
        end
        n_s3_in = w_in_ax[0] && w_in_ax[1];

        n_s3_org[0]  = origin_of(r_grid_left, 5'(r_s2_col), FRACTION_BITS);
        n_s3_org[1]  = origin_of(r_grid_top,  5'(r_s2_row), FRACTION_BITS);
        w_rst_org[0] = origin_of(RESET_LEFT,  5'(r_s2_col), FRACTION_BITS);
        w_rst_org[1] = origin_of(RESET_TOP,   5'(r_s2_row), FRACTION_BITS);

        for (int a = 0; a < 2; a++) begin
            n_s3_pos[a] = r_s2_init ? $signed(r_s2_mem.pos[a]) : $signed(w_rst_org[a]);
            n_s3_vel[a] = r_s2_init ? $signed(r_s2_mem.vel[a]) : '0;
        end
    end

    // ------------------------------------------------------------------ stage 3: target
    always_comb begin
        w_off[0] = r_s3_in ? offset_at(r_s3_cell[1], r_s3_cell[0]) : 3'sd0;
        w_off[1] = r_s3_in ? offset_at(r_s3_cell[0], r_s3_cell[1]) : 3'sd0;
        for (int a = 0; a < 2; a++) begin
            n_s4_tgt[a] = $signed({1'b0, r_s3_org[a]}) + (21'(w_off[a]) <<< FRACTION_BITS);
        end
    end

    // ------------------------------------------------------------------ stage 4: damping product
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_s5_pd[a]  = 41'(r_s4_vel[a]) * 41'($signed({1'b0, r_damping}));
            n_s5_err[a] = 22'(r_s4_tgt[a]) - 22'(r_s4_pos[a]);
        end
    end

    // ------------------------------------------------------------------ stage 5: spring product
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_s6_rd[a] = round_q16(r_s5_pd[a]);
            n_s6_ps[a] = 29'(r_s5_err[a]) * 29'($signed({1'b0, r_stiffness}));
        end
    end

    // ------------------------------------------------------------------ stage 6: new velocity
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_vs[a] = 30'(r_s6_rd[a]) + 30'(r_s6_ps[a]);
            if (w_vs[a][29:VEL_W-1] != {(31-VEL_W){w_vs[a][29]}}) begin
                n_s7_vel[a] = w_vs[a][29] ? VEL_MIN : VEL_MAX;
            end else begin
                n_s7_vel[a] = w_vs[a][VEL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------ stage 7: step product
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_s8_pe[a] = 41'(r_s7_vel[a]) * 41'($signed({1'b0, r_s7_el}));
        end
    end

    // ------------------------------------------------------------------ stage 8: new position
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_ps[a] = 26'(r_s8_pos[a]) + 26'(round_q16(r_s8_pe[a]));
            if (w_ps[a][25:POS_W-1] != {(27-POS_W){w_ps[a][25]}}) begin
                w_pn[a] = w_ps[a][25] ? POS_MIN : POS_MAX;
            end else begin
                w_pn[a] = w_ps[a][POS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------ pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_cur[0] <= i_cursor_x;
            r_s1_cur[1] <= i_cursor_y;
            r_s1_el     <= i_elapsed;

            r_s2_row  <= n_s2_row;
            r_s2_col  <= n_s2_col;
            r_s2_el   <= r_s1_el;
            r_s2_mem  <= r_s1_mem;
            r_s2_init <= r_s1_init;

            r_s3_in <= n_s3_in;
            r_s3_el <= r_s2_el;
            r_s4_el <= r_s3_el;
            r_s4_in <= r_s3_in;
            r_s5_el <= r_s4_el;
            r_s5_in <= r_s4_in;
            r_s6_el <= r_s5_el;
            r_s6_in <= r_s5_in;
            r_s7_el <= r_s6_el;
            r_s7_in <= r_s6_in;
            r_s8_in <= r_s7_in;

            for (int a = 0; a < 2; a++) begin
                r_s2_cur[a]  <= r_s1_cur[a];
                r_s3_org[a]  <= n_s3_org[a];
                r_s3_cell[a] <= n_s3_cell[a];
                r_s3_pos[a]  <= n_s3_pos[a];
                r_s3_vel[a]  <= n_s3_vel[a];
                r_s4_tgt[a]  <= n_s4_tgt[a];
                r_s4_pos[a]  <= r_s3_pos[a];
                r_s4_vel[a]  <= r_s3_vel[a];
                r_s5_pd[a]   <= n_s5_pd[a];
                r_s5_err[a]  <= n_s5_err[a];
                r_s5_pos[a]  <= r_s4_pos[a];
                r_s6_rd[a]   <= n_s6_rd[a];
                r_s6_ps[a]   <= n_s6_ps[a];
                r_s6_pos[a]  <= r_s5_pos[a];
                r_s7_vel[a]  <= n_s7_vel[a];
                r_s7_pos[a]  <= r_s6_pos[a];
                r_s8_pe[a]   <= n_s8_pe[a];
                r_s8_vel[a]  <= r_s7_vel[a];
                r_s8_pos[a]  <= r_s7_pos[a];
            end
        end
    end

    // ------------------------------------------------------------------ result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_pid <= r_pid[NS-1];
            r_o_in  <= r_rng[NS-1] && r_s8_in;
            for (int a = 0; a < 2; a++) begin
                // drop the update for a particle outside the grid
                r_o_pos[a] <= r_rng[NS-1] ? w_pn[a] : '0;
            end
        end
    end

    assign o_valid        = r_o_vld;
    assign o_particle_out = r_o_pid;
    assign o_pos_x        = r_o_pos[0];
    assign o_pos_y        = r_o_pos[1];
    assign o_in_window    = r_o_in;

    // ------------------------------------------------------------------ checks
    `SPGU_ASSERT_NOW(a_stall_backpressure, i_clk, i_rst_n, (o_valid && i_stall), o_stall, "input not held while result is blocked")
    `SPGU_ASSERT_NOW(a_no_rmw_collision, i_clk, i_rst_n, (w_we && w_accept && w_in_rng), (w_wr_addr != i_particle[AW-1:0]), "state read collides with write-back")
    `SPGU_ASSERT_NOW(a_outside_grid_zero, i_clk, i_rst_n, (o_valid && int'(o_particle_out) >= NUM), (o_pos_x == '0 && o_pos_y == '0 && !o_in_window), "result for particle outside grid not zero")

endmodule

`default_nettype wire
